@@ rtl/smp_pkg.sv @@
package smp_pkg;

	// Configuration register layout
	localparam int CFG_W      = 11;
	localparam int WSZ_W      = 3;
	localparam int CFG_IDX_W  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_WINDOW_SIZE  = 2'd2
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd28;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd28;
	localparam logic [WSZ_W-1:0] WSIZE_RST  = 3'd2;

	// Image height limit and result field widths
	localparam int               MAX_HEIGHT = 1024;
	localparam int               ROW_W      = 10;
	localparam int               COORD_W    = 10;
	localparam int               POOLED_W   = 15;
	localparam logic [POOLED_W-1:0] POOLED_MAX = 15'h7fff;

endpackage

@@ rtl/sliding_max_pool_2d_top.sv @@
// Stride-1 max pooling over a raster-order pixel stream: takes one pixel per cycle unless
// stalled and, once a window_size x window_size window is complete, delivers its maximum
// (floored at zero, capped at 32767) with the window's top-left row and column, flagging
// the last result of the image. A pixel passes through three register stages (line-buffer
// read, window shift, max tree into the result register). The line buffers are MAX_WINDOW-1
// single-port-per-cycle memories, each read once per pixel, with only the buffer of the
// pixel's row written. Configuration writes are taken at any time but must only be issued
// between images.
module sliding_max_pool_2d_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_WINDOW = 4,
	parameter int PIXEL_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// configuration write channel
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [smp_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [smp_pkg::CFG_W-1:0]              cfg_data,
	// pixel channel
	input  logic                                   pix_valid,
	output logic                                   pix_stall,
	input  logic signed [PIXEL_BITS-1:0]           pixel,
	// result channel
	output logic                                   res_valid,
	input  logic                                   res_stall,
	output logic [smp_pkg::POOLED_W-1:0]           pooled,
	output logic [smp_pkg::COORD_W-1:0]            out_row,
	output logic [smp_pkg::COORD_W-1:0]            out_col,
	output logic                                   last_of_image
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = (CW + 1 > smp_pkg::CFG_W) ? CW + 1 : smp_pkg::CFG_W;
	localparam int HW    = smp_pkg::CFG_W;
	localparam int KW    = $clog2(MAX_WINDOW + 1);
	localparam int KX    = (KW > smp_pkg::WSZ_W) ? KW : smp_pkg::WSZ_W;
	localparam int LINES = MAX_WINDOW - 1;
	localparam int SW    = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int MV    = PIXEL_BITS - 1;
	localparam int MX    = (MV > smp_pkg::POOLED_W) ? MV : smp_pkg::POOLED_W;

	function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
		slot_inc = (s == SW'(LINES - 1)) ? '0 : s + SW'(1);
	endfunction

	// configuration registers
	logic [smp_pkg::CFG_W-1:0] width_q;
	logic [smp_pkg::CFG_W-1:0] height_q;
	logic [smp_pkg::WSZ_W-1:0] wsize_q;

	// raster counters
	logic [CW-1:0]           col_q;
	logic [smp_pkg::ROW_W-1:0] row_q;
	logic [SW-1:0]           slot_q;

	// handshake
	logic accept, adv1, adv2, load_out, s1_free, s2_free, out_free;
	logic v_s1, v_s2, res_valid_q;

	// clamped settings
	logic [WW-1:0] w_cl;
	logic [HW-1:0] h_cl;
	logic [KX-1:0] ws_cl;

	// position of the pixel being taken and counters after it
	logic [WW-1:0] c_a, c_n;
	logic [HW-1:0] r_a, r_n;
	logic [SW-1:0] slot_a, slot_n;
	logic [CW-1:0] col_n;
	logic          emit_a, last_a;
	logic [WW-1:0] ocol_a;
	logic [HW-1:0] orow_a;

	// stage 1
	logic [PIXEL_BITS-1:0]      px_s1;
	logic [PIXEL_BITS-1:0]      rd_s1 [LINES];
	logic [SW-1:0]              slot_s1;
	logic [KX-1:0]              ws_s1;
	logic                       emit_s1, last_s1;
	logic [smp_pkg::COORD_W-1:0] orow_s1, ocol_s1;

	// stage 2
	logic [KX-1:0]              ws_s2;
	logic                       emit_s2, last_s2;
	logic [smp_pkg::COORD_W-1:0] orow_s2, ocol_s2;

	// line buffers and window
	logic [PIXEL_BITS-1:0] line_mem [LINES][MAX_WIDTH];
	logic [PIXEL_BITS-1:0] win_q    [MAX_WINDOW][MAX_WINDOW];
	logic [PIXEL_BITS-1:0] col_new  [MAX_WINDOW];
	logic [4:0]            sel_t    [MAX_WINDOW];
	logic [KX-1:0]         back_k   [MAX_WINDOW];

	// max tree
	logic [MV-1:0]          row_max [MAX_WINDOW];
	logic [MV-1:0]          win_max;
	logic [MX-1:0]          win_max_x;
	logic [smp_pkg::POOLED_W-1:0] pooled_n;

	// result register
	logic [smp_pkg::POOLED_W-1:0] pooled_q;
	logic [smp_pkg::COORD_W-1:0]  out_row_q, out_col_q;
	logic                         last_q;

	assign cfg_ready = 1'b1;

	// take configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= smp_pkg::WIDTH_RST;
			height_q <= smp_pkg::HEIGHT_RST;
			wsize_q  <= smp_pkg::WSIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (smp_pkg::cfg_reg_t'(cfg_index))
				smp_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				smp_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				smp_pkg::REG_WINDOW_SIZE:  wsize_q  <= cfg_data[smp_pkg::WSZ_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp settings into their legal ranges
	always_comb begin
		if (width_q == '0)
			w_cl = WW'(1);
		else if (WW'(width_q) > WW'(MAX_WIDTH))
			w_cl = WW'(MAX_WIDTH);
		else
			w_cl = WW'(width_q);

		if (height_q == '0)
			h_cl = HW'(1);
		else if (height_q > HW'(smp_pkg::MAX_HEIGHT))
			h_cl = HW'(smp_pkg::MAX_HEIGHT);
		else
			h_cl = height_q;

		if (wsize_q == '0)
			ws_cl = KX'(1);
		else if (KX'(wsize_q) > KX'(MAX_WINDOW))
			ws_cl = KX'(MAX_WINDOW);
		else
			ws_cl = KX'(wsize_q);
	end

	// handshake across the three stages
	assign out_free = !res_valid_q || !res_stall;
	assign adv2     = v_s2 && (out_free || !emit_s2);
	assign load_out = adv2 && emit_s2;
	assign s2_free  = !v_s2 || adv2;
	assign adv1     = v_s1 && s2_free;
	assign s1_free  = !v_s1 || adv1;
	assign pix_stall = !s1_free;
	assign accept   = pix_valid && s1_free;

	// position of the incoming pixel, window emit check and next counters
	always_comb begin
		if (WW'(col_q) >= w_cl) begin
			c_a    = '0;
			r_a    = HW'(row_q) + HW'(1);
			slot_a = slot_inc(slot_q);
		end else begin
			c_a    = WW'(col_q);
			r_a    = HW'(row_q);
			slot_a = slot_q;
		end
		if (r_a >= h_cl) begin
			r_a    = '0;
			slot_a = '0;
		end

		emit_a = (r_a + HW'(1) >= HW'(ws_cl)) && (c_a + WW'(1) >= WW'(ws_cl));
		last_a = (r_a + HW'(1) >= h_cl) && (c_a + WW'(1) >= w_cl);
		orow_a = r_a + HW'(1) - HW'(ws_cl);
		ocol_a = c_a + WW'(1) - WW'(ws_cl);

		c_n = c_a + WW'(1);
		if (c_n >= w_cl) begin
			col_n  = '0;
			r_n    = r_a + HW'(1);
			slot_n = slot_inc(slot_a);
			if (r_n >= h_cl) begin
				r_n    = '0;
				slot_n = '0;
			end
		end else begin
			col_n  = c_n[CW-1:0];
			r_n    = r_a;
			slot_n = slot_a;
		end
	end

	// advance raster counters per accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (accept) begin
			col_q  <= col_n;
			row_q  <= r_n[smp_pkg::ROW_W-1:0];
			slot_q <= slot_n;
		end
	end

	// read all line buffers at the column, write the pixel into its row's buffer
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int b = 0; b < LINES; b++) begin
				rd_s1[b] <= line_mem[b][c_a[CW-1:0]];
				if (slot_a == SW'(b))
					line_mem[b][c_a[CW-1:0]] <= pixel;
			end
		end
	end

	// stage valid bits and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept)
				v_s1 <= 1'b1;
			else if (adv1)
				v_s1 <= 1'b0;
			if (adv1)
				v_s2 <= 1'b1;
			else if (adv2)
				v_s2 <= 1'b0;
			if (load_out)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= pixel;
			slot_s1 <= slot_a;
			ws_s1   <= ws_cl;
			emit_s1 <= emit_a;
			last_s1 <= last_a;
			orow_s1 <= orow_a[smp_pkg::COORD_W-1:0];
			ocol_s1 <= ocol_a[smp_pkg::COORD_W-1:0];
		end
	end

	// build the new window column: current pixel at the bottom row, older rows from buffers
	always_comb begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			back_k[i] = ws_s1 - KX'(1) - KX'(i);
			sel_t[i]  = 5'(slot_s1) + 5'(LINES) - 5'(back_k[i]);
			if (sel_t[i] >= 5'(LINES))
				sel_t[i] = sel_t[i] - 5'(LINES);
			if (KX'(i + 1) == ws_s1)
				col_new[i] = px_s1;
			else if (KX'(i) < ws_s1)
				col_new[i] = rd_s1[sel_t[i][SW-1:0]];
			else
				col_new[i] = '0;
		end
	end

	// shift the window one column left and load the new column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_WINDOW; i++)
				for (int j = 0; j < MAX_WINDOW; j++)
					win_q[i][j] <= '0;
		end else if (adv1) begin
			for (int i = 0; i < MAX_WINDOW; i++) begin
				for (int j = 0; j < MAX_WINDOW - 1; j++)
					win_q[i][j] <= win_q[i][j + 1];
				win_q[i][MAX_WINDOW-1] <= col_new[i];
			end
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (adv1) begin
			ws_s2   <= ws_s1;
			emit_s2 <= emit_s1;
			last_s2 <= last_s1;
			orow_s2 <= orow_s1;
			ocol_s2 <= ocol_s1;
		end
	end

	// max over the active window, negatives count as zero
	always_comb begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			row_max[i] = '0;
			for (int j = 0; j < MAX_WINDOW; j++) begin
				if ((KX'(i) < ws_s2) && (KX'(j) >= KX'(MAX_WINDOW) - ws_s2) &&
				    !win_q[i][j][PIXEL_BITS-1] && (win_q[i][j][MV-1:0] > row_max[i]))
					row_max[i] = win_q[i][j][MV-1:0];
			end
		end
		win_max = '0;
		for (int i = 0; i < MAX_WINDOW; i++)
			if (row_max[i] > win_max)
				win_max = row_max[i];
		win_max_x = MX'(win_max);
		if (win_max_x > MX'(smp_pkg::POOLED_MAX))
			pooled_n = smp_pkg::POOLED_MAX;
		else
			pooled_n = win_max_x[smp_pkg::POOLED_W-1:0];
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_out) begin
			pooled_q  <= pooled_n;
			out_row_q <= orow_s2;
			out_col_q <= ocol_s2;
			last_q    <= last_s2;
		end
	end

	assign res_valid     = res_valid_q;
	assign pooled        = pooled_q;
	assign out_row       = out_row_q;
	assign out_col       = out_col_q;
	assign last_of_image = last_q;

	// an empty first stage always takes the next item
	a_s1_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !pix_stall)
		else $error("pixel stalled while first stage empty");

	// a result only appears from an emitting window in stage 2
	a_res_from_s2: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(v_s2 && emit_s2))
		else $error("result without an emitting window");

	// line-buffer slot stays within the buffer count
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SW'(LINES - 1))
		else $error("line slot out of range");

	// column counter stays within the line buffer depth
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(WW'(col_q) < WW'(MAX_WIDTH)))
		else $error("column counter out of range");

endmodule

@@ sim/tb.sv @@
typedef logic signed [15:0] pix_t;
typedef logic [smp_pkg::CFG_W-1:0] cfg_word_t;

localparam int POOL_MAX_WIDTH  = 1024;
localparam int POOL_MAX_WINDOW = 4;
localparam int POOL_LINES      = POOL_MAX_WINDOW - 1;

typedef struct packed {
	logic [smp_pkg::POOLED_W-1:0] pooled;
	logic [smp_pkg::COORD_W-1:0]  row;
	logic [smp_pkg::COORD_W-1:0]  col;
	logic                         last;
} pool_res_t;

// Predicts pooled results from accepted pixels and checks the block's output against them
class pool_tracker;
	logic [smp_pkg::CFG_W-1:0] width_reg;
	logic [smp_pkg::CFG_W-1:0] height_reg;
	logic [smp_pkg::WSZ_W-1:0] wsize_reg;
	pix_t             line_buf [POOL_LINES][POOL_MAX_WIDTH];
	pix_t             win [POOL_MAX_WINDOW][POOL_MAX_WINDOW];
	int               row_cnt;
	int               col_cnt;
	pool_res_t        pending_pools[$];
	int               mismatches;
	int               results_seen;

	function new();
		width_reg    = smp_pkg::WIDTH_RST;
		height_reg   = smp_pkg::HEIGHT_RST;
		wsize_reg    = smp_pkg::WSIZE_RST;
		foreach (line_buf[i, j]) line_buf[i][j] = '0;
		foreach (win[i, j]) win[i][j] = '0;
		row_cnt      = 0;
		col_cnt      = 0;
		mismatches   = 0;
		results_seen = 0;
	endfunction

	function void set_reg(smp_pkg::cfg_reg_t idx, logic [smp_pkg::CFG_W-1:0] data);
		case (idx)
		smp_pkg::REG_IMAGE_WIDTH: width_reg = data;
		smp_pkg::REG_IMAGE_HEIGHT: height_reg = data;
		smp_pkg::REG_WINDOW_SIZE: wsize_reg = data[smp_pkg::WSZ_W-1:0];
		default: ;
		endcase
	endfunction

	// Clamp register values to the bounds the block honors
	function int eff_width();
		if (width_reg == 0) return 1;
		if (width_reg > POOL_MAX_WIDTH) return POOL_MAX_WIDTH;
		return int'(width_reg);
	endfunction

	function int eff_height();
		if (height_reg == 0) return 1;
		if (height_reg > smp_pkg::MAX_HEIGHT) return smp_pkg::MAX_HEIGHT;
		return int'(height_reg);
	endfunction

	function int eff_wsize();
		if (wsize_reg == 0) return 1;
		if (wsize_reg > POOL_MAX_WINDOW) return POOL_MAX_WINDOW;
		return int'(wsize_reg);
	endfunction

	function int image_pixels();
		return eff_width() * eff_height();
	endfunction

	function void take_pixel(pix_t px);
		int        w;
		int        h;
		int        ws;
		int        r;
		int        c;
		int        k;
		int        slot;
		int        top;
		int        orow;
		int        ocol;
		pool_res_t want;
		w  = eff_width();
		h  = eff_height();
		ws = eff_wsize();
		// wrap counters against the current bounds
		if (col_cnt >= w) begin
			col_cnt = 0;
			row_cnt++;
		end
		if (row_cnt >= h) row_cnt = 0;
		r = row_cnt;
		c = col_cnt;
		// shift the window left and load the new column from the line buffers
		for (int i = 0; i < POOL_MAX_WINDOW; i++) begin
			for (int j = 0; j < POOL_MAX_WINDOW - 1; j++) win[i][j] = win[i][j + 1];
			if (i + 1 == ws) begin
				win[i][POOL_MAX_WINDOW - 1] = px;
			end else if (i < ws) begin
				k    = ws - 1 - i;
				slot = (r % POOL_LINES + POOL_LINES - k) % POOL_LINES;
				win[i][POOL_MAX_WINDOW - 1] = line_buf[slot][c];
			end else begin
				win[i][POOL_MAX_WINDOW - 1] = '0;
			end
		end
		line_buf[r % POOL_LINES][c] = px;
		// emit once the window is complete; the maximum starts at zero
		if (r + 1 >= ws && c + 1 >= ws) begin
			top = 0;
			for (int i = 0; i < ws; i++)
				for (int j = POOL_MAX_WINDOW - ws; j < POOL_MAX_WINDOW; j++)
					if (win[i][j] > top) top = win[i][j];
			orow        = r + 1 - ws;
			ocol        = c + 1 - ws;
			want.pooled = top[smp_pkg::POOLED_W-1:0];
			want.row    = orow[smp_pkg::COORD_W-1:0];
			want.col    = ocol[smp_pkg::COORD_W-1:0];
			want.last   = (r + 1 >= h) && (c + 1 >= w);
			pending_pools.insert(pending_pools.size(), want);
		end
		// advance to the next pixel position
		col_cnt = c + 1;
		if (col_cnt >= w) begin
			col_cnt = 0;
			row_cnt = r + 1;
			if (row_cnt >= h) row_cnt = 0;
		end
	endfunction

	function void log_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10) $display("MISMATCH: %s", msg);
	endfunction

	function void check_result(pool_res_t got);
		pool_res_t want;
		results_seen++;
		if (pending_pools.size() == 0) begin
			log_mismatch($sformatf("unexpected result pooled=%0d row=%0d col=%0d last=%0d",
				got.pooled, got.row, got.col, got.last));
			return;
		end
		want = pending_pools.pop_front();
		if (got.pooled !== want.pooled || got.row !== want.row ||
				got.col !== want.col || got.last !== want.last)
			log_mismatch($sformatf(
				"expected pooled=%0d row=%0d col=%0d last=%0d, got %0d %0d %0d %0d",
				want.pooled, want.row, want.col, want.last,
				got.pooled, got.row, got.col, got.last));
	endfunction
endclass

module tb;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 16;
	localparam int IDLE_LIMIT   = 2000;
	localparam int ITEMS_TARGET = 950;

	typedef enum {FLOW, LIGHT, HEAVY, EVERY_FOURTH, BURSTY} stall_mode_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [smp_pkg::CFG_IDX_W-1:0] cfg_index = smp_pkg::REG_IMAGE_WIDTH;
	logic [smp_pkg::CFG_W-1:0]     cfg_data  = '0;
	logic                          pix_valid = 1'b0;
	logic                          pix_stall;
	pix_t                          pixel     = '0;
	logic                          res_valid;
	logic                          res_stall = 1'b0;
	logic [smp_pkg::POOLED_W-1:0]  pooled;
	logic [smp_pkg::COORD_W-1:0]   out_row;
	logic [smp_pkg::COORD_W-1:0]   out_col;
	logic                          last_of_image;

	pool_tracker tracker;
	int          burst_left   = 0;
	bit          drain        = 1'b0;
	int          hold_asked   = 0;
	int          hold_given   = 0;
	int          pixels_sent  = 0;
	int          settings_run = 0;
	int          idle_cycles  = 0;

	sliding_max_pool_2d_top #(
		.MAX_WIDTH(POOL_MAX_WIDTH),
		.MAX_WINDOW(POOL_MAX_WINDOW),
		.PIXEL_BITS(16)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pixel(pixel),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.pooled(pooled),
		.out_row(out_row),
		.out_col(out_col),
		.last_of_image(last_of_image)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Check every accepted result
	always @(posedge clk) begin
		if (res_valid && !res_stall)
			tracker.check_result(pool_res_t'{pooled, out_row, out_col, last_of_image});
	end

	// End the run if nothing moves for too long
	always @(posedge clk) begin
		if ((pix_valid && !pix_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TIMEOUT: no item moved for %0d cycles", IDLE_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Drive the result stall: long hold on request, none while draining, else a mode pattern
	initial begin : receiver
		stall_mode_t mode;
		int          mode_left;
		int          held;
		int          tick;
		mode      = FLOW;
		mode_left = 0;
		held      = 0;
		tick      = 0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_given < hold_asked) begin
				res_stall <= 1'b1;
				held++;
				if (held >= HOLD_CYCLES) begin
					held = 0;
					hold_given++;
				end
			end else if (drain) begin
				res_stall <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = stall_mode_t'($urandom_range(0, 4));
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				case (mode)
				FLOW: res_stall <= 1'b0;
				LIGHT: res_stall <= ($urandom_range(0, 9) < 3);
				HEAVY: res_stall <= ($urandom_range(0, 9) < 7);
				EVERY_FOURTH: res_stall <= (tick % 4 == 0);
				default: res_stall <= (tick % 16 >= 10);
				endcase
			end
		end
	end

	// Offer one pixel, opening a new burst, mostly after a random gap, when the current one runs out
	task automatic send_pixel(pix_t px);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				@(negedge clk);
				pix_valid <= 1'b0;
				repeat ($urandom_range(0, 10)) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
			                                         : $urandom_range(1, 30);
		end
		burst_left--;
		@(negedge clk);
		pix_valid <= 1'b1;
		pixel     <= px;
		do @(posedge clk); while (pix_stall);
		tracker.take_pixel(px);
		pixels_sent++;
	endtask

	// Stop sending, let every expected result come out, then give the pipeline time to empty
	task automatic wait_drained();
		@(negedge clk);
		pix_valid <= 1'b0;
		drain = 1'b1;
		while (tracker.pending_pools.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		drain      = 1'b0;
		burst_left = 0;
	endtask

	task automatic write_cfg(smp_pkg::cfg_reg_t idx, logic [smp_pkg::CFG_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic setup(cfg_word_t w, cfg_word_t h, cfg_word_t wsd);
		wait_drained();
		write_cfg(smp_pkg::REG_IMAGE_WIDTH, w);
		write_cfg(smp_pkg::REG_IMAGE_HEIGHT, h);
		write_cfg(smp_pkg::REG_WINDOW_SIZE, wsd);
		settings_run++;
	endtask

	function automatic pix_t rand_pixel(bit negative);
		if (negative) return pix_t'(0 - int'($urandom_range(1, 32768)));
		case ($urandom_range(0, 9))
		0, 1, 2, 3: return pix_t'($urandom);
		4, 5: return pix_t'(0 - int'($urandom_range(1, 32768)));
		6: begin
			case ($urandom_range(0, 3))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sh0000;
			default: return 16'shffff;
			endcase
		end
		default: return pix_t'(int'($urandom_range(0, 200)) - 100);
		endcase
	endfunction

	// Mostly small sides, sometimes medium, rarely a zero register value
	function automatic cfg_word_t pick_side();
		case ($urandom_range(0, 9))
		0, 1, 2, 3, 4, 5, 6: return cfg_word_t'($urandom_range(1, 8));
		7, 8: return cfg_word_t'($urandom_range(9, 16));
		default: return '0;
		endcase
	endfunction

	// Pixels along one side as the block counts them (a zero register means one)
	function automatic int side_px(cfg_word_t s);
		return (s == '0) ? 1 : int'(s);
	endfunction

	task automatic run_images(cfg_word_t w, cfg_word_t h, cfg_word_t wsd, int n,
			bit negative, bit with_hold);
		int total;
		setup(w, h, wsd);
		if (with_hold) hold_asked++;
		total = n * tracker.image_pixels();
		repeat (total) send_pixel(rand_pixel(negative));
	endtask

	initial begin : stimulus
		pix_t        corner_px [9];
		int          n;
		int          left;
		int unsigned ext_bits;
		cfg_word_t   w;
		cfg_word_t   h;
		cfg_word_t   wsd;
		tracker   = new();
		corner_px = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001,
		              16'sh4000, 16'shc000, 16'sh5555, 16'sh2aaa};
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// one image at the reset settings
		repeat (tracker.image_pixels()) send_pixel(rand_pixel(1'b0));
		settings_run++;

		// extremes of the pixel value on a 3x3 image, window 2
		setup(11'd3, 11'd3, 11'd2);
		foreach (corner_px[i]) send_pixel(corner_px[i]);
		// window larger than the image: no result
		setup(11'd2, 11'd2, 11'd3);
		repeat (4) send_pixel(rand_pixel(1'b0));
		// window of one on a single row
		setup(11'd3, 11'd1, 11'd1);
		repeat (3) send_pixel(rand_pixel(1'b0));
		// all negative: result floors at zero
		setup(11'd2, 11'd2, 11'd2);
		repeat (4) send_pixel(rand_pixel(1'b1));

		// long receiver hold while pixels keep coming
		run_images(11'd8, 11'd8, 11'd2, 1, 1'b0, 1'b1);

		// random settings, complete images only, kept within the item budget
		while (pixels_sent < ITEMS_TARGET) begin
			case ($urandom_range(0, 9))
			8: wsd = '0;
			9: wsd = cfg_word_t'($urandom_range(5, 7));
			default: wsd = cfg_word_t'($urandom_range(1, 4));
			endcase
			if ($urandom_range(0, 3) == 0) begin
				ext_bits = $urandom;
				wsd[smp_pkg::CFG_W-1:smp_pkg::WSZ_W] =
					ext_bits[smp_pkg::CFG_W-smp_pkg::WSZ_W-1:0];
			end
			n    = $urandom_range(1, 3);
			w    = pick_side();
			h    = pick_side();
			left = ITEMS_TARGET - pixels_sent;
			if (n * side_px(w) * side_px(h) > left) begin
				n = 1;
				if (side_px(w) > left) w = cfg_word_t'(left);
				h = cfg_word_t'(left / side_px(w));
			end
			run_images(w, h, wsd, n, $urandom_range(0, 5) == 0,
				$urandom_range(0, 19) == 0);
		end

		wait_drained();
		$display("Pooled %0d pixels under %0d register settings: reset values, zero sides,",
			pixels_sent, settings_run);
		$display("windows from zero to seven and beyond the image; %0d results, %0d bad.",
			tracker.results_seen, tracker.mismatches);
		if (tracker.mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
